// ===== rtl/itda_pkg.sv =====
// itda_pkg: types, constants and the double-dabble step shared by the
// signed integer to decimal ASCII converter. No dependencies.
package itda_pkg;

    localparam int unsigned BIN_W      = 32;               // magnitude width
    localparam int unsigned DIGITS     = 10;               // decimal digits of 2^32-1
    localparam int unsigned BITS_STG   = 4;                // shift steps per stage
    localparam int unsigned CONV_STG   = BIN_W / BITS_STG; // conversion stages
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned IDX_W      = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;   // '-' masked to 6 bits
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;   // '0' masked to 6 bits

    typedef logic [DIGITS-1:0][3:0] t_bcd;
    typedef logic [BIN_W-1:0]       t_bin;
    typedef logic [IDX_W-1:0]       t_idx;

    // One double-dabble step: correct every digit of five or more, then
    // shift the whole BCD word left, taking in the next binary bit.
    function automatic t_bcd dd_step(t_bcd b, logic bit_in);
        t_bcd                    a;
        logic [4*DIGITS-1:0]     flat;
        begin
            a = b;
            for (int k = 0; k < DIGITS; k++) begin
                if (a[k] >= 4'd5) begin
                    a[k] = a[k] + 4'd3;
                end
            end
            flat = a;
            return t_bcd'({flat[4*DIGITS-2:0], bit_in});
        end
    endfunction

endpackage

// ===== rtl/int_to_decimal_ascii_top.sv =====
// int_to_decimal_ascii_top: signed 32-bit integer to decimal ASCII text.
// Depends on itda_pkg (widths, character codes, double-dabble step).
//
//  channel  | valid    | ready    | payload                  | per transaction
//  ---------+----------+----------+--------------------------+-------------------------
//  input    | i_valid  | o_ready  | i_value[31:0] signed     | one integer
//  output   | o_valid  | i_ready  | o_character[5:0], o_last | one character, MS first
//
// An integer passes an input register and eight conversion stages (four
// double-dabble shifts each), then a serialiser that emits one character
// per cycle unless the output stalls, for 1..11 characters per integer
// (minus sign included). It loads between numbers, taking no new integer
// until the previous one is out. Reset clears all valid bits; the conversion
// pipeline holds its contents while the serialiser or the output stalls.
module int_to_decimal_ascii_top
    import itda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BIN_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    // conversion pipeline: stage 0 holds the magnitude, stages 1..CONV_STG
    logic        r_vld [0:CONV_STG];
    t_bcd        r_bcd [0:CONV_STG];
    t_bin        r_bin [0:CONV_STG];
    logic        r_neg [0:CONV_STG];

    t_bcd        n_bcd [1:CONV_STG];
    t_bin        n_bin [1:CONV_STG];
    logic        stg_en [0:CONV_STG];

    // serialiser
    logic        r_s_busy;
    t_bcd        r_s_dig;
    t_idx        r_s_idx;
    logic        r_s_neg;
    t_idx        n_s_top;
    logic        s_take;
    logic        s_emit;

    // output register
    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_last;
    logic              out_free;

    assign out_free = !r_o_valid || i_ready;
    assign s_emit   = r_s_busy && out_free;
    assign s_take   = r_vld[CONV_STG] && !r_s_busy;

    // stage enables, from the serialiser back to the input
    always_comb begin
        stg_en[CONV_STG] = !r_vld[CONV_STG] || s_take;
        for (int j = CONV_STG - 1; j >= 0; j--) begin
            stg_en[j] = !r_vld[j] || stg_en[j+1];
        end
    end

    assign o_ready = stg_en[0];

    // four double-dabble steps per stage
    always_comb begin
        for (int j = 1; j <= CONV_STG; j++) begin
            n_bcd[j] = r_bcd[j-1];
            n_bin[j] = r_bin[j-1];
            for (int s = 0; s < BITS_STG; s++) begin
                n_bcd[j] = dd_step(n_bcd[j], n_bin[j][BIN_W-1]);
                n_bin[j] = {n_bin[j][BIN_W-2:0], 1'b0};
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_bcd[0] <= '0;
            r_bin[0] <= i_value[BIN_W-1] ? (~i_value + 1'b1) : i_value;
            r_neg[0] <= i_value[BIN_W-1];
        end
        for (int j = 1; j <= CONV_STG; j++) begin
            if (stg_en[j]) begin
                r_bcd[j] <= n_bcd[j];
                r_bin[j] <= n_bin[j];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= CONV_STG; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j <= CONV_STG; j++) begin
                if (stg_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    // most significant non-zero digit; zero gives digit 0 alone
    always_comb begin
        n_s_top = '0;
        for (int k = 1; k < DIGITS; k++) begin
            if (r_bcd[CONV_STG][k] != 4'd0) begin
                n_s_top = t_idx'(k);
            end
        end
    end

    // serialiser: minus sign first, then digits down to digit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_busy <= 1'b0;
        end else if (s_take) begin
            r_s_busy <= 1'b1;
        end else if (s_emit && !r_s_neg && r_s_idx == '0) begin
            r_s_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_s_dig <= r_bcd[CONV_STG];
            r_s_idx <= n_s_top;
            r_s_neg <= r_neg[CONV_STG];
        end else if (s_emit) begin
            if (r_s_neg) begin
                r_s_neg <= 1'b0;
            end else if (r_s_idx != '0) begin
                r_s_idx <= r_s_idx - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            if (r_s_neg) begin
                r_o_char <= CHAR_MINUS;
                r_o_last <= 1'b0;
            end else begin
                r_o_char <= CHAR_ZERO + {2'b00, r_s_dig[r_s_idx]};
                r_o_last <= (r_s_idx == '0);
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

endmodule
